// File: sv/rctg_pkg.sv
// ----------------------------------------------------------------------------
// rctg_pkg
// shared constants, codes, types and helpers of the raycast texel generator
// ----------------------------------------------------------------------------
package rctg_pkg;

  localparam int TILE           = 64;
  localparam int TILE_W         = $clog2(TILE);
  localparam int SCREEN_HEIGHT  = 512;
  localparam int SCREEN_COLUMNS = 512;
  localparam int HALF           = SCREEN_HEIGHT / 2;
  localparam int COL_MID        = SCREEN_COLUMNS / 2;

  localparam int NUM_W   = 20 + TILE_W;
  localparam int DIV_N   = 40;
  localparam int DIV_D   = 24;
  localparam int SIN_LAT = 4;
  localparam int CFG_AW  = 5;

  localparam logic [15:0] H_SAT = 16'hFFFF;
  localparam logic [23:0] D_SAT = 24'hFFFFFF;

  localparam logic [1:0] SURF_CEIL  = 2'd0;
  localparam logic [1:0] SURF_FLOOR = 2'd1;
  localparam logic [1:0] SURF_WALL  = 2'd2;

  localparam logic [2:0] REG_PX    = 3'd0;
  localparam logic [2:0] REG_PY    = 3'd1;
  localparam logic [2:0] REG_PA    = 3'd2;
  localparam logic [2:0] REG_PPD   = 3'd3;
  localparam logic [2:0] REG_ASTEP = 3'd4;
  localparam logic [2:0] REG_TW    = 3'd5;
  localparam logic [2:0] REG_TH    = 3'd6;

  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] pa;
    logic [19:0] ppd;
    logic [15:0] astep;
    logic [8:0]  tw;
    logic [8:0]  th;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [8:0]         column;
    logic [8:0]         row;
    logic [23:0]        ray_dist;
    logic [15:0]        rdiff;
    logic [23:0]        hx;
    logic [23:0]        hy;
    logic               vert;
    logic               sd_neg;
    logic [15:0]        mag;
    logic [15:0]        view;
    logic [23:0]        perp;
    logic [23:0]        dvs;
    logic               dsat;
    logic signed [15:0] ccur;
    logic signed [15:0] scur;
    logic [15:0]        h;
    logic               degen;
    logic [23:0]        d;
    logic [1:0]         surface;
    logic [24:0]        prod_v;
    logic signed [40:0] prod_x;
    logic signed [40:0] prod_y;
    logic [TILE_W-1:0]  m_x;
    logic [TILE_W-1:0]  m_y;
    logic [7:0]         pu;
    logic [7:0]         pv;
  } pix_t;

  function automatic logic [8:0] clamp_tex(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    return r;
  endfunction

endpackage

// File: sv/rctg_ifs.sv
// ----------------------------------------------------------------------------
// rctg_ifs
// pixel request and texel result channels, valid/ready
// ----------------------------------------------------------------------------
interface rctg_in_if;
  logic        valid;
  logic        ready;
  logic [8:0]  column;
  logic [8:0]  row;
  logic [23:0] ray_distance;
  logic [15:0] ray_angle;
  logic [23:0] hit_x;
  logic [23:0] hit_y;
  logic        hit_vertical;
  modport source(output valid, column, row, ray_distance, ray_angle, hit_x, hit_y,
                 hit_vertical, input ready);
  modport sink(input valid, column, row, ray_distance, ray_angle, hit_x, hit_y,
               hit_vertical, output ready);
endinterface

interface rctg_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] out_column;
  logic [8:0] out_row;
  logic [1:0] surface;
  logic [7:0] tex_u;
  logic [7:0] tex_v;
  logic       degenerate;
  modport source(output valid, out_column, out_row, surface, tex_u, tex_v, degenerate,
                 input ready);
  modport sink(input valid, out_column, out_row, surface, tex_u, tex_v, degenerate,
               output ready);
endinterface

// File: sv/raycast_column_texel_generator.sv
// ----------------------------------------------------------------------------
// raycast_column_texel_generator
// maps a screen pixel and its column's ray hit to surface and texel coords
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// in_pix    in   valid/ready     column row ray_distance ray_angle hit_x hit_y
//                                hit_vertical
// out_pix   out  valid/ready     out_column out_row surface tex_u tex_v degenerate
// apb       in   psel/penable    paddr pwdata prdata, pready tied high
//
// one beat per cycle while the output is not stalled; the path runs through two chained
// 40 stage divider pipelines (strip height, then wall v)
// synchronous active low reset clears all stage valid bits
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module raycast_column_texel_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  rctg_in_if.sink                     in_pix,
  rctg_out_if.source                  out_pix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rctg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rctg_pkg::*;

  localparam int C_LEN = DIV_N - 2;

  cfg_t  cfg;
  logic  en;
  logic [8:0] tw, th, th_m1;
  logic [NUM_W-1:0] num;

  pix_t s0_r, s0_nxt;
  pix_t a_in;
  pix_t dla_r [SIN_LAT];
  pix_t s5_r, s5_nxt;
  pix_t dlb_r [DIV_N];
  pix_t s6_r, s6_nxt;
  pix_t s7_r, s7_nxt;
  pix_t s8_r, s8_nxt;
  pix_t s9_r, s9_nxt;
  pix_t dlc_r [C_LEN];

  logic [8:0]  absd;
  logic [24:0] mag_full;
  logic [15:0] view, cur;
  logic signed [15:0] cos_ray, cos_view, cos_cur, sin_cur;
  logic [38:0] perp_full;
  logic [8:0]  rd;
  logic [23:0] rdcv;
  logic [DIV_N-1:0] q1, q3, q2;
  logic [14:0] hh;
  logic [16:0] top, bottom, sum;
  logic [15:0] dft;
  logic signed [40:0] wx, wy;
  logic [14:0] mu, mv;

  logic       out_valid_r, out_valid_nxt;
  logic [8:0] out_col_r, out_row_r;
  logic [1:0] out_surf_r;
  logic [7:0] out_u_r, out_v_r, out_u_nxt, out_v_nxt;
  logic       out_deg_r, out_deg_nxt;
  pix_t       fin;

  rctg_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign en           = !out_valid_r || out_pix.ready;
  assign in_pix.ready = en;
  assign tw           = clamp_tex(cfg.tw);
  assign th           = clamp_tex(cfg.th);
  assign th_m1        = th - 9'd1;
  assign num          = NUM_W'(cfg.ppd) << TILE_W;

  // accept and column angle offset
  always_comb begin
    s0_nxt          = '0;
    s0_nxt.valid    = in_pix.valid;
    s0_nxt.column   = in_pix.column;
    s0_nxt.row      = in_pix.row;
    s0_nxt.ray_dist = in_pix.ray_distance;
    s0_nxt.rdiff    = in_pix.ray_angle - cfg.pa;
    s0_nxt.hx       = in_pix.hit_x;
    s0_nxt.hy       = in_pix.hit_y;
    s0_nxt.vert     = in_pix.hit_vertical;
    s0_nxt.sd_neg   = in_pix.column < 9'(COL_MID);
    absd            = s0_nxt.sd_neg ? 9'(COL_MID) - in_pix.column
                                    : in_pix.column - 9'(COL_MID);
    mag_full        = {16'd0, absd} * {9'd0, cfg.astep};
    s0_nxt.mag      = mag_full[23:8];
  end

  always_comb begin
    view      = s0_r.sd_neg ? 16'd0 - s0_r.mag : s0_r.mag;
    cur       = cfg.pa + view;
    a_in      = s0_r;
    a_in.view = view;
  end

  rctg_sin u_cos_ray  (.clk(clk), .en(en), .angle(s0_r.rdiff + 16'h4000), .value(cos_ray));
  rctg_sin u_cos_view (.clk(clk), .en(en), .angle(view + 16'h4000), .value(cos_view));
  rctg_sin u_cos_cur  (.clk(clk), .en(en), .angle(cur + 16'h4000), .value(cos_cur));
  rctg_sin u_sin_cur  (.clk(clk), .en(en), .angle(cur), .value(sin_cur));

  // fisheye correction and plane divisor
  always_comb begin
    s5_nxt      = dla_r[SIN_LAT-1];
    perp_full   = {15'd0, s5_nxt.ray_dist} * {24'd0, cos_ray[14:0]};
    s5_nxt.perp = (cos_ray > 16'sd0) ? perp_full[37:14] : 24'd0;
    rd          = (s5_nxt.row >= 9'(HALF)) ? s5_nxt.row - 9'(HALF)
                                          : 9'(HALF) - s5_nxt.row;
    rdcv        = {15'd0, rd} * {9'd0, cos_view[14:0]};
    s5_nxt.dvs  = {rdcv[22:0], 1'b0};
    s5_nxt.dsat = !(cos_view > 16'sd0) || (rd == 9'd0);
    s5_nxt.ccur = cos_cur;
    s5_nxt.scur = sin_cur;
  end

  rctg_div u_div_h (
    .clk(clk), .en(en), .dividend(DIV_N'(num)), .divisor(s5_r.perp), .quotient(q1)
  );
  rctg_div u_div_d (
    .clk(clk), .en(en), .dividend(DIV_N'(num) << 14), .divisor(s5_r.dvs), .quotient(q3)
  );

  // strip height and plane distance saturation
  always_comb begin
    s6_nxt = dlb_r[DIV_N-1];
    if (s6_nxt.perp == 24'd0) begin
      s6_nxt.h     = H_SAT;
      s6_nxt.degen = 1'b1;
    end else begin
      s6_nxt.h     = (q1 > DIV_N'(H_SAT)) ? H_SAT : q1[15:0];
      s6_nxt.degen = 1'b0;
    end
    if (s6_nxt.dsat) s6_nxt.d = D_SAT;
    else             s6_nxt.d = (q3 > DIV_N'(D_SAT)) ? D_SAT : q3[23:0];
  end

  // classify and start products
  always_comb begin
    s7_nxt = s6_r;
    hh     = s6_r.h[15:1];
    top    = ({2'd0, hh} >= 17'(HALF)) ? 17'd0 : 17'(HALF) - {2'd0, hh};
    bottom = ({2'd0, hh} + 17'(HALF) > 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT)
                                                           : {2'd0, hh} + 17'(HALF);
    priority if ({8'd0, s6_r.row} < top) s7_nxt.surface = SURF_CEIL;
    else if ({8'd0, s6_r.row} > bottom)  s7_nxt.surface = SURF_FLOOR;
    else                                 s7_nxt.surface = SURF_WALL;
    if (s7_nxt.surface != SURF_WALL && s6_r.dsat) s7_nxt.degen = 1'b1;
    sum           = {8'd0, s6_r.row} + {2'd0, hh};
    dft           = (sum > 17'(HALF)) ? 16'(sum - 17'(HALF)) : 16'd0;
    s7_nxt.prod_v = {9'd0, dft} * {16'd0, th};
    s7_nxt.prod_x = $signed({17'd0, s6_r.d}) * s6_r.ccur;
    s7_nxt.prod_y = $signed({17'd0, s6_r.d}) * s6_r.scur;
  end

  rctg_div u_div_v (
    .clk(clk), .en(en), .dividend(DIV_N'(s7_r.prod_v)), .divisor(DIV_D'(s7_r.h)),
    .quotient(q2)
  );

  // plane world point, tile index
  always_comb begin
    s8_nxt     = s7_r;
    wx         = $signed({3'd0, cfg.px, 14'd0}) + s7_r.prod_x;
    wy         = $signed({3'd0, cfg.py, 14'd0}) + s7_r.prod_y;
    s8_nxt.m_x = wx[TILE_W+21:22];
    s8_nxt.m_y = wy[TILE_W+21:22];
  end

  // scale tile index to texture size
  always_comb begin
    s9_nxt    = s8_r;
    mu        = 15'(({9'd0, s8_r.m_x} * {6'd0, tw}) >> TILE_W);
    mv        = 15'(({9'd0, s8_r.m_y} * {6'd0, th}) >> TILE_W);
    s9_nxt.pu = mu[7:0];
    s9_nxt.pv = mv[7:0];
  end

  // final select
  always_comb begin
    fin           = dlc_r[C_LEN-1];
    out_valid_nxt = fin.valid;
    out_deg_nxt   = fin.degen;
    if (fin.surface == SURF_WALL) begin
      out_u_nxt = 8'(fin.vert ? fin.hy[TILE_W+7:8] : fin.hx[TILE_W+7:8]);
      if (fin.h == 16'd0) begin
        out_v_nxt   = th_m1[7:0];
        out_deg_nxt = 1'b1;
      end else begin
        out_v_nxt = (q2 > DIV_N'(th_m1)) ? th_m1[7:0] : q2[7:0];
      end
    end else begin
      out_u_nxt = fin.pu;
      out_v_nxt = fin.pv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r        <= '0;
      s5_r        <= '0;
      s6_r        <= '0;
      s7_r        <= '0;
      s8_r        <= '0;
      s9_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SIN_LAT; i++) dla_r[i] <= '0;
      for (int i = 0; i < DIV_N; i++)   dlb_r[i] <= '0;
      for (int i = 0; i < C_LEN; i++)   dlc_r[i] <= '0;
    end else if (en) begin
      s0_r     <= s0_nxt;
      dla_r[0] <= a_in;
      for (int i = 1; i < SIN_LAT; i++) dla_r[i] <= dla_r[i-1];
      s5_r     <= s5_nxt;
      dlb_r[0] <= s5_r;
      for (int i = 1; i < DIV_N; i++) dlb_r[i] <= dlb_r[i-1];
      s6_r     <= s6_nxt;
      s7_r     <= s7_nxt;
      s8_r     <= s8_nxt;
      s9_r     <= s9_nxt;
      dlc_r[0] <= s9_r;
      for (int i = 1; i < C_LEN; i++) dlc_r[i] <= dlc_r[i-1];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_col_r  <= fin.column;
      out_row_r  <= fin.row;
      out_surf_r <= fin.surface;
      out_u_r    <= out_u_nxt;
      out_v_r    <= out_v_nxt;
      out_deg_r  <= out_deg_nxt;
    end
  end

  assign out_pix.valid      = out_valid_r;
  assign out_pix.out_column = out_col_r;
  assign out_pix.out_row    = out_row_r;
  assign out_pix.surface    = out_surf_r;
  assign out_pix.tex_u      = out_u_r;
  assign out_pix.tex_v      = out_v_r;
  assign out_pix.degenerate = out_deg_r;

endmodule

// File: sv/rctg_cfg.sv
// ----------------------------------------------------------------------------
// rctg_cfg
// apb register file holding player pose, projection and texture sizes
// ----------------------------------------------------------------------------
module rctg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rctg_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output rctg_pkg::cfg_t               cfg
);
  import rctg_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.px    <= '0;
      cfg_r.py    <= '0;
      cfg_r.pa    <= '0;
      cfg_r.ppd   <= 20'd113510;
      cfg_r.astep <= 16'd5461;
      cfg_r.tw    <= 9'd64;
      cfg_r.th    <= 9'd64;
    end else if (wr) begin
      unique case (idx)
        REG_PX:    cfg_r.px    <= pwdata[23:0];
        REG_PY:    cfg_r.py    <= pwdata[23:0];
        REG_PA:    cfg_r.pa    <= pwdata[15:0];
        REG_PPD:   cfg_r.ppd   <= pwdata[19:0];
        REG_ASTEP: cfg_r.astep <= pwdata[15:0];
        REG_TW:    cfg_r.tw    <= pwdata[8:0];
        REG_TH:    cfg_r.th    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PX:    prdata = {8'd0, cfg_r.px};
      REG_PY:    prdata = {8'd0, cfg_r.py};
      REG_PA:    prdata = {16'd0, cfg_r.pa};
      REG_PPD:   prdata = {12'd0, cfg_r.ppd};
      REG_ASTEP: prdata = {16'd0, cfg_r.astep};
      REG_TW:    prdata = {23'd0, cfg_r.tw};
      REG_TH:    prdata = {23'd0, cfg_r.th};
      default:   prdata = '0;
    endcase
  end

endmodule

// File: sv/rctg_sin.sv
// ----------------------------------------------------------------------------
// rctg_sin
// four stage polynomial sine, q14 result from a 16 bit binary angle
// ----------------------------------------------------------------------------
module rctg_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [15:0] value
);
  import rctg_pkg::*;

  logic [14:0] t0;
  logic [29:0] sq;
  logic [14:0] t1_r, t2_r, t3_r;
  logic        n1_r, n2_r, n3_r;
  logic [14:0] q1_r, q2_r;
  logic [25:0] pa;
  logic [10:0] a2_r;
  logic [29:0] pb;
  logic [13:0] b3_r;
  logic [29:0] pc;
  logic [15:0] s;
  logic signed [15:0] value_r;

  always_comb begin
    t0 = {1'b0, angle[13:0]};
    if (angle[14]) t0 = 15'd16384 - t0;
    sq = {15'd0, t0} * {15'd0, t0};
    pa = {11'd0, q1_r} * 26'd1160;
    pb = {15'd0, q2_r} * {16'd0, 14'd10512 - {3'd0, a2_r}};
    pc = {15'd0, t3_r} * {15'd0, 15'd25736 - {1'b0, b3_r}};
    s  = pc[29:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= t0;
      n1_r    <= angle[15];
      q1_r    <= sq[28:14];
      t2_r    <= t1_r;
      n2_r    <= n1_r;
      q2_r    <= q1_r;
      a2_r    <= pa[24:14];
      t3_r    <= t2_r;
      n3_r    <= n2_r;
      b3_r    <= pb[27:14];
      value_r <= n3_r ? -$signed(s) : $signed(s);
    end
  end

  assign value = value_r;

endmodule

// File: sv/rctg_div.sv
// ----------------------------------------------------------------------------
// rctg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rctg_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rctg_pkg::DIV_N-1:0] dividend,
  input  logic [rctg_pkg::DIV_D-1:0] divisor,
  output logic [rctg_pkg::DIV_N-1:0] quotient
);
  import rctg_pkg::*;

  logic [DIV_D-1:0] rem_r [DIV_N];
  logic [DIV_N-1:0] dq_r  [DIV_N];
  logic [DIV_D-1:0] dvs_r [DIV_N];

  for (genvar i = 0; i < DIV_N; i++) begin : g_st
    logic [DIV_D-1:0] rem_in;
    logic [DIV_D-1:0] dvs_in;
    logic [DIV_N-1:0] dq_in;
    logic [DIV_D:0]   sh;
    logic [DIV_D:0]   df;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dq_in  = dq_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end
    assign sh = {rem_in, dq_in[DIV_N-1]};
    assign df = sh - {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[i] <= dvs_in;
        if (!df[DIV_D]) begin
          rem_r[i] <= df[DIV_D-1:0];
          dq_r[i]  <= {dq_in[DIV_N-2:0], 1'b1};
        end else begin
          rem_r[i] <= sh[DIV_D-1:0];
          dq_r[i]  <= {dq_in[DIV_N-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = dq_r[DIV_N-1];

endmodule
